[hw/rtl/pnf_pkg.sv]
package pnf_pkg;

   localparam int TABLE_SIZE_DEF  = 256;
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int ENTRY_W    = 8;
   localparam int NOISE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCTAVE_COUNT  = 3'd0,
      CSR_LACUNARITY    = 3'd1,
      CSR_GAIN          = 3'd2,
      CSR_RIDGED_MODE   = 3'd3,
      CSR_INVERT_OUTPUT = 3'd4,
      CSR_INVERSE_SCALE = 3'd5
   } csr_index_type;

   localparam logic [3:0]  OCTAVE_COUNT_RST  = 4'd4;
   localparam logic [15:0] LACUNARITY_RST    = 16'd8192;
   localparam logic [15:0] GAIN_RST          = 16'd32768;
   localparam logic        RIDGED_MODE_RST   = 1'b0;
   localparam logic        INVERT_OUTPUT_RST = 1'b0;
   localparam logic [23:0] INVERSE_SCALE_RST = 24'd65536;

endpackage

[hw/rtl/pnf_if.sv]
interface pnf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic        [pnf_pkg::INDEX_W-1:0]   table_index;
   logic        [pnf_pkg::ENTRY_W-1:0]   table_value;
   logic signed [pnf_pkg::COORD_W-1:0]   coord_x;
   logic signed [pnf_pkg::COORD_W-1:0]   coord_y;

   modport source (output valid, func, table_index, table_value, coord_x, coord_y,
                   input ready);
   modport sink (input valid, func, table_index, table_value, coord_x, coord_y,
                 output ready);
endinterface

interface pnf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pnf_pkg::NOISE_W-1:0]   noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

interface pnf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pnf_pkg::CSR_IDX_W-1:0]    index;
   logic [pnf_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/pnf_div.sv]
module pnf_div #(
   parameter int SUM_W = 40,
   parameter int TOT_W = 20,
   parameter int Q_W   = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [TOT_W-1:0] divisor,
   output logic                    done,
   output logic signed [Q_W:0]     quotient
);

   localparam int DV_W = TOT_W + Q_W;
   localparam int CW   = $clog2(Q_W);

   logic            busy_ff;
   logic            done_ff;
   logic [CW-1:0]   cnt_ff;
   logic [DV_W-1:0] rem_ff;
   logic [DV_W-1:0] den_ff;
   logic [Q_W-1:0]  quo_ff;
   logic            neg_ff;

   logic [SUM_W-1:0] mag;
   logic             fit;
   logic [DV_W-1:0]  rem_in;

   always_comb begin
      mag    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      fit    = rem_ff >= den_ff;
      rem_in = fit ? rem_ff - den_ff : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CW'(Q_W - 1);
         rem_ff <= DV_W'(mag);
         den_ff <= DV_W'(divisor) << (Q_W - 1);
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= rem_in;
         den_ff <= den_ff >> 1;
         quo_ff <= {quo_ff[Q_W-2:0], fit};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

[hw/rtl/perlin_noise_2d_fbm.sv]
// Two-dimensional gradient noise with octave summation. A table write item stores one
// byte of the permutation table and returns nothing. An evaluate item scales the
// coordinates, runs one pass per octave and then divides: every product goes through one
// shared 33x33 multiplier, one per cycle, 21 of them in each octave with the six table
// reads overlapped on the memory's single read port, and the final normalisation runs
// through a restoring divider at one quotient bit per cycle. One evaluation is in flight
// at a time; a finished result waits in the output register while the next item is taken.
// The table comes up undefined and is not cleared by the block.
module perlin_noise_2d_fbm #(
   parameter int TABLE_SIZE  = pnf_pkg::TABLE_SIZE_DEF,
   parameter int MAX_OCTAVES = pnf_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = pnf_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   pnf_req_if.sink   req_port,
   pnf_rsp_if.source rsp_port,
   pnf_csr_if.sink   csr_port
);

   localparam int TB   = $clog2(TABLE_SIZE);
   localparam int AW   = ((TB > pnf_pkg::ENTRY_W) ? TB : pnf_pkg::ENTRY_W) + 1;
   localparam int NW   = FRAC_BITS + 6;
   localparam int QSH  = 44 - FRAC_BITS;
   localparam int SUMW = FRAC_BITS + 24;
   localparam int TOTW = 17 + $clog2(MAX_OCTAVES);
   localparam int QW   = FRAC_BITS + 3;
   localparam int OW   = FRAC_BITS + 14;
   localparam int OCW  = $clog2(MAX_OCTAVES + 1);
   localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SH_L = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

   localparam logic signed [NW-1:0] ONE_N = NW'(2 ** FRAC_BITS);
   localparam logic signed [NW-1:0] C10   = NW'(10 * 2 ** FRAC_BITS);
   localparam logic signed [NW-1:0] C15   = NW'(15 * 2 ** FRAC_BITS);
   localparam logic signed [OW-1:0] ONE_O = OW'(2 ** FRAC_BITS);
   localparam logic signed [OW-1:0] SAT_O = OW'(65535);
   localparam logic [63:0]          FREQ_INIT = 64'd4096;
   localparam logic [16:0]          AMP_INIT  = 17'd65536;

   typedef enum logic [5:0] {
      ST_IDLE, ST_PX, ST_PY, ST_PT,
      ST_QXLL, ST_QXHL, ST_QXLH, ST_QYLL, ST_QYHL, ST_QYLH,
      ST_FX1, ST_FX2, ST_FX3, ST_FX4, ST_FY1, ST_FY2, ST_FY3, ST_FY4,
      ST_BLO, ST_BHI, ST_BHV, ST_BFIN, ST_BNV, ST_BSUM,
      ST_AAMP, ST_AFL, ST_AFH, ST_AFN,
      ST_DGO, ST_DWAIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [pnf_pkg::NOISE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [3:0]  oct_cnt_ff;
   logic [15:0] lac_ff;
   logic [15:0] gain_ff;
   logic        ridged_ff;
   logic        invert_ff;
   logic [23:0] inv_scale_ff;

   logic [pnf_pkg::ENTRY_W-1:0] perm_mem [TABLE_SIZE];
   logic [pnf_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [TB-1:0]               rd_addr;
   logic                        mem_we;
   logic                        req_xfer;

   logic signed [pnf_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [63:0] px_ff, py_ff, freq_ff, acc_ff;
   logic [63:0] px_in, py_in, freq_in, acc_in, qsum;
   logic [TB-1:0] ix_ff, iy_ff, ix_in, iy_in;
   logic [FRAC_BITS-1:0] xf_ff, yf_ff, xf_in, yf_in;
   logic signed [NW-1:0] inner_ff, u_ff, v_ff, lo_ff, hi_ff, nv_ff;
   logic signed [NW-1:0] inner_in, u_in, v_in, lo_in, hi_in, nv_in;
   logic [pnf_pkg::ENTRY_W-1:0] pa_ff, pb_ff, pa_in, pb_in;
   logic [2:0] haa_ff, hab_ff, hba_ff, hbb_ff, haa_in, hab_in, hba_in, hbb_in;
   logic [16:0] amp_ff, amp_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [TOTW-1:0] total_ff, total_in;
   logic [OCW-1:0] oct_ff, oct_in, n_lim;
   logic [OCW:0] oct_nx;
   logic last_oct;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] p_ff, p_sh;
   logic signed [NW-1:0] p_n;

   logic signed [NW-1:0] xs, xm, ys, ym, g_aa, g_ab, g_ba, g_bb, n_raw, n_abs;
   logic [AW-1:0] pa_sum, pb_sum;

   logic div_start, div_done;
   logic signed [QW:0] div_q;
   logic signed [OW-1:0] r0, r1, r2, r3;
   logic [pnf_pkg::NOISE_W-1:0] noise;

   function automatic logic signed [NW-1:0] grad(input logic [2:0] h,
                                                 input logic signed [NW-1:0] gx,
                                                 input logic signed [NW-1:0] gy);
      logic signed [NW-1:0] gu, gv, tu, tv;
      gu = h[2] ? gy : gx;
      gv = h[2] ? gx : gy;
      tu = h[0] ? -gu : gu;
      tv = h[1] ? -(gv <<< 1) : (gv <<< 1);
      return tu + tv;
   endfunction

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_port.valid && req_port.ready;
   assign mem_we         = req_xfer && (req_port.func == pnf_pkg::FUNC_WRITE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.noise_value = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cnt_ff   <= pnf_pkg::OCTAVE_COUNT_RST;
         lac_ff       <= pnf_pkg::LACUNARITY_RST;
         gain_ff      <= pnf_pkg::GAIN_RST;
         ridged_ff    <= pnf_pkg::RIDGED_MODE_RST;
         invert_ff    <= pnf_pkg::INVERT_OUTPUT_RST;
         inv_scale_ff <= pnf_pkg::INVERSE_SCALE_RST;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            pnf_pkg::CSR_OCTAVE_COUNT:  oct_cnt_ff   <= csr_port.data[3:0];
            pnf_pkg::CSR_LACUNARITY:    lac_ff       <= csr_port.data[15:0];
            pnf_pkg::CSR_GAIN:          gain_ff      <= csr_port.data[15:0];
            pnf_pkg::CSR_RIDGED_MODE:   ridged_ff    <= csr_port.data[0];
            pnf_pkg::CSR_INVERT_OUTPUT: invert_ff    <= csr_port.data[0];
            pnf_pkg::CSR_INVERSE_SCALE: inv_scale_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[TB'(req_port.table_index)] <= req_port.table_value;
      end
      rd_data_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   assign p_sh = p_ff >>> FRAC_BITS;
   assign p_n  = signed'(p_sh[NW-1:0]);

   always_comb begin
      n_lim = (oct_cnt_ff == 4'd0) ? OCW'(1) :
              (({1'b0, oct_cnt_ff} > 5'(MAX_OCTAVES)) ? OCW'(MAX_OCTAVES) : OCW'(oct_cnt_ff));
      oct_nx   = {1'b0, oct_ff} + 1'b1;
      last_oct = (oct_nx == {1'b0, n_lim});
   end

   always_comb begin
      xs = signed'(NW'(xf_ff));
      ys = signed'(NW'(yf_ff));
      xm = xs - ONE_N;
      ym = ys - ONE_N;
      g_aa = grad(haa_ff, xs, ys);
      g_ba = grad(hba_ff, xm, ys);
      g_ab = grad(hab_ff, xs, ym);
      g_bb = grad(hbb_ff, xm, ym);
      qsum = acc_ff + {p_ff[31:0], 32'b0};
      pa_sum = AW'(pa_ff) + AW'(iy_ff);
      pb_sum = AW'(pb_ff) + AW'(iy_ff);
      n_raw = lo_ff + p_n;
      n_abs = n_raw[NW-1] ? -n_raw : n_raw;
   end

   always_comb begin
      px_in = px_ff;  py_in = py_ff;  freq_in = freq_ff;  acc_in = acc_ff;
      ix_in = ix_ff;  iy_in = iy_ff;  xf_in = xf_ff;  yf_in = yf_ff;
      inner_in = inner_ff;  u_in = u_ff;  v_in = v_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  nv_in = nv_ff;
      pa_in = pa_ff;  pb_in = pb_ff;
      haa_in = haa_ff;  hab_in = hab_ff;  hba_in = hba_ff;  hbb_in = hbb_ff;
      amp_in = amp_ff;  sum_in = sum_ff;  total_in = total_ff;  oct_in = oct_ff;
      mul_a = '0;
      mul_b = '0;
      rd_addr = ix_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_PX: begin
            mul_a = 33'(x_ff);
            mul_b = signed'(33'(inv_scale_ff));
         end
         ST_PY: begin
            px_in = p_ff[63:0];
            mul_a = 33'(y_ff);
            mul_b = signed'(33'(inv_scale_ff));
         end
         ST_PT: begin
            py_in    = p_ff[63:0];
            freq_in  = FREQ_INIT;
            amp_in   = AMP_INIT;
            sum_in   = '0;
            total_in = '0;
            oct_in   = '0;
         end
         ST_QXLL: begin
            mul_a = signed'({1'b0, px_ff[31:0]});
            mul_b = signed'({1'b0, freq_ff[31:0]});
         end
         ST_QXHL: begin
            acc_in = p_ff[63:0];
            mul_a  = signed'({1'b0, px_ff[63:32]});
            mul_b  = signed'({1'b0, freq_ff[31:0]});
         end
         ST_QXLH: begin
            acc_in = qsum;
            mul_a  = signed'({1'b0, px_ff[31:0]});
            mul_b  = signed'({1'b0, freq_ff[63:32]});
         end
         ST_QYLL: begin
            ix_in = qsum[44 +: TB];
            xf_in = qsum[QSH +: FRAC_BITS];
            mul_a = signed'({1'b0, py_ff[31:0]});
            mul_b = signed'({1'b0, freq_ff[31:0]});
         end
         ST_QYHL: begin
            acc_in = p_ff[63:0];
            mul_a  = signed'({1'b0, py_ff[63:32]});
            mul_b  = signed'({1'b0, freq_ff[31:0]});
         end
         ST_QYLH: begin
            acc_in = qsum;
            mul_a  = signed'({1'b0, py_ff[31:0]});
            mul_b  = signed'({1'b0, freq_ff[63:32]});
         end
         ST_FX1: begin
            iy_in   = qsum[44 +: TB];
            yf_in   = qsum[QSH +: FRAC_BITS];
            rd_addr = ix_ff;
            mul_a   = 33'(xs);
            mul_b   = 33'((xs <<< 2) + (xs <<< 1) - C15);
         end
         ST_FX2: begin
            inner_in = p_n + C10;
            pa_in    = rd_data_ff;
            rd_addr  = ix_ff + 1'b1;
            mul_a    = 33'(xs);
            mul_b    = 33'(xs);
         end
         ST_FX3: begin
            pb_in   = rd_data_ff;
            rd_addr = pa_sum[TB-1:0];
            mul_a   = 33'(p_n);
            mul_b   = 33'(xs);
         end
         ST_FX4: begin
            haa_in  = rd_data_ff[2:0];
            rd_addr = pa_sum[TB-1:0] + 1'b1;
            mul_a   = 33'(p_n);
            mul_b   = 33'(inner_ff);
         end
         ST_FY1: begin
            u_in    = p_n;
            hab_in  = rd_data_ff[2:0];
            rd_addr = pb_sum[TB-1:0];
            mul_a   = 33'(ys);
            mul_b   = 33'((ys <<< 2) + (ys <<< 1) - C15);
         end
         ST_FY2: begin
            inner_in = p_n + C10;
            hba_in   = rd_data_ff[2:0];
            rd_addr  = pb_sum[TB-1:0] + 1'b1;
            mul_a    = 33'(ys);
            mul_b    = 33'(ys);
         end
         ST_FY3: begin
            hbb_in = rd_data_ff[2:0];
            mul_a  = 33'(p_n);
            mul_b  = 33'(ys);
         end
         ST_FY4: begin
            mul_a = 33'(p_n);
            mul_b = 33'(inner_ff);
         end
         ST_BLO: begin
            v_in  = p_n;
            mul_a = 33'(u_ff);
            mul_b = 33'(g_ba - g_aa);
         end
         ST_BHI: begin
            lo_in = g_aa + p_n;
            mul_a = 33'(u_ff);
            mul_b = 33'(g_bb - g_ab);
         end
         ST_BHV: begin
            hi_in = g_ab + p_n;
         end
         ST_BFIN: begin
            mul_a = 33'(v_ff);
            mul_b = 33'(hi_ff - lo_ff);
         end
         ST_BNV: begin
            nv_in = ridged_ff ? ONE_N - n_abs : n_raw;
         end
         ST_BSUM: begin
            mul_a = signed'(33'(amp_ff));
            mul_b = 33'(nv_ff);
         end
         ST_AAMP: begin
            sum_in   = sum_ff + signed'(p_ff[SUMW-1:0]);
            total_in = total_ff + TOTW'(amp_ff);
            mul_a    = signed'(33'(amp_ff));
            mul_b    = signed'(33'(gain_ff));
         end
         ST_AFL: begin
            amp_in = p_ff[32:16];
            mul_a  = signed'({1'b0, freq_ff[31:0]});
            mul_b  = signed'(33'(lac_ff));
         end
         ST_AFH: begin
            acc_in = p_ff[63:0];
            mul_a  = signed'({1'b0, freq_ff[63:32]});
            mul_b  = signed'(33'(lac_ff));
         end
         ST_AFN: begin
            freq_in = qsum >> 12;
            oct_in  = oct_nx[OCW-1:0];
         end
         ST_DGO: begin
            div_start = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff <= req_port.coord_x;
         y_ff <= req_port.coord_y;
      end
      px_ff <= px_in;  py_ff <= py_in;  freq_ff <= freq_in;  acc_ff <= acc_in;
      ix_ff <= ix_in;  iy_ff <= iy_in;  xf_ff <= xf_in;  yf_ff <= yf_in;
      inner_ff <= inner_in;  u_ff <= u_in;  v_ff <= v_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  nv_ff <= nv_in;
      pa_ff <= pa_in;  pb_ff <= pb_in;
      haa_ff <= haa_in;  hab_ff <= hab_in;  hba_ff <= hba_in;  hbb_ff <= hbb_in;
      amp_ff <= amp_in;  sum_ff <= sum_in;  total_ff <= total_in;  oct_ff <= oct_in;
   end

   pnf_div #(
      .SUM_W (SUMW),
      .TOT_W (TOTW),
      .Q_W   (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      r0 = OW'(div_q);
      r1 = ridged_ff ? r0 : ((r0 + ONE_O) >>> 1);
      r2 = invert_ff ? ONE_O - r1 : r1;
      r3 = (r2 >>> SH_R) <<< SH_L;
      if (r3[OW-1]) begin
         noise = '0;
      end else if (r3 > SAT_O) begin
         noise = '1;
      end else begin
         noise = r3[pnf_pkg::NOISE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_port.func == pnf_pkg::FUNC_EVAL) begin
               state_in = ST_PX;
            end
         end
         ST_PX:   state_in = ST_PY;
         ST_PY:   state_in = ST_PT;
         ST_PT:   state_in = ST_QXLL;
         ST_QXLL: state_in = ST_QXHL;
         ST_QXHL: state_in = ST_QXLH;
         ST_QXLH: state_in = ST_QYLL;
         ST_QYLL: state_in = ST_QYHL;
         ST_QYHL: state_in = ST_QYLH;
         ST_QYLH: state_in = ST_FX1;
         ST_FX1:  state_in = ST_FX2;
         ST_FX2:  state_in = ST_FX3;
         ST_FX3:  state_in = ST_FX4;
         ST_FX4:  state_in = ST_FY1;
         ST_FY1:  state_in = ST_FY2;
         ST_FY2:  state_in = ST_FY3;
         ST_FY3:  state_in = ST_FY4;
         ST_FY4:  state_in = ST_BLO;
         ST_BLO:  state_in = ST_BHI;
         ST_BHI:  state_in = ST_BHV;
         ST_BHV:  state_in = ST_BFIN;
         ST_BFIN: state_in = ST_BNV;
         ST_BNV:  state_in = ST_BSUM;
         ST_BSUM: state_in = ST_AAMP;
         ST_AAMP: state_in = ST_AFL;
         ST_AFL:  state_in = ST_AFH;
         ST_AFH:  state_in = ST_AFN;
         ST_AFN:  state_in = last_oct ? ST_DGO : ST_QXLL;
         ST_DGO:  state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = noise;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_port.func == pnf_pkg::FUNC_WRITE) |=> !$rose(rsp_valid_ff))
      else $error("table write produced a result");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DWAIT))
      else $error("divider finished outside the wait state");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QXLL) |-> (oct_ff < n_lim))
      else $error("octave counter beyond limit");
`endif

endmodule
